// ===== rtl/core/hpack_pkg.sv =====
// Shared constants, tables and types for the HPACK Huffman string decoder.
// Holds the canonical code tables of the static code. No dependencies.
package hpack_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int MAX_CODE_BITS = 30;
  localparam int PAD_LIMIT = 7;
  localparam logic [8:0] EOS_SYMBOL = 9'd256;

  // Result status codes
  localparam logic [2:0] ST_SYMBOL = 3'd0;
  localparam logic [2:0] ST_DONE = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_NUL = 3'd3;
  localparam logic [2:0] ST_PADDING = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  // Codes of each bit length, index = length (last entry is spare)
  localparam logic [5:0] CODE_COUNT [32] = '{
    6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd10, 6'd26, 6'd32, 6'd6, 6'd0, 6'd5, 6'd3, 6'd2,
    6'd6, 6'd2, 6'd3, 6'd0, 6'd0, 6'd0, 6'd3, 6'd8, 6'd13, 6'd26, 6'd29, 6'd12,
    6'd4, 6'd15, 6'd19, 6'd29, 6'd0, 6'd4, 6'd0
  };

  // Octet symbols in canonical order: by code length, then by code value.
  // EOS holds the last canonical index and is not stored.
  localparam logic [8:0] CODE_SYMBOL [256] = '{
    9'd48, 9'd49, 9'd50, 9'd97, 9'd99, 9'd101, 9'd105, 9'd111, 9'd115, 9'd116,
    9'd32, 9'd37, 9'd45, 9'd46, 9'd47, 9'd51, 9'd52, 9'd53, 9'd54, 9'd55, 9'd56,
    9'd57, 9'd61, 9'd65, 9'd95, 9'd98, 9'd100, 9'd102, 9'd103, 9'd104, 9'd108,
    9'd109, 9'd110, 9'd112, 9'd114, 9'd117,
    9'd58, 9'd66, 9'd67, 9'd68, 9'd69, 9'd70, 9'd71, 9'd72, 9'd73, 9'd74, 9'd75,
    9'd76, 9'd77, 9'd78, 9'd79, 9'd80, 9'd81, 9'd82, 9'd83, 9'd84, 9'd85, 9'd86,
    9'd87, 9'd89, 9'd106, 9'd107, 9'd113, 9'd118, 9'd119, 9'd120, 9'd121, 9'd122,
    9'd38, 9'd42, 9'd44, 9'd59, 9'd88, 9'd90,
    9'd33, 9'd34, 9'd40, 9'd41, 9'd63,
    9'd39, 9'd43, 9'd124,
    9'd35, 9'd62,
    9'd0, 9'd36, 9'd64, 9'd91, 9'd93, 9'd126,
    9'd94, 9'd125,
    9'd60, 9'd96, 9'd123,
    9'd92, 9'd195, 9'd208,
    9'd128, 9'd130, 9'd131, 9'd162, 9'd184, 9'd194, 9'd224, 9'd226,
    9'd153, 9'd161, 9'd167, 9'd172, 9'd176, 9'd177, 9'd179, 9'd209, 9'd216,
    9'd217, 9'd227, 9'd229, 9'd230,
    9'd129, 9'd132, 9'd133, 9'd134, 9'd136, 9'd146, 9'd154, 9'd156, 9'd160,
    9'd163, 9'd164, 9'd169, 9'd170, 9'd173, 9'd178, 9'd181, 9'd185, 9'd186,
    9'd187, 9'd189, 9'd190, 9'd196, 9'd198, 9'd228, 9'd232, 9'd233,
    9'd1, 9'd135, 9'd137, 9'd138, 9'd139, 9'd140, 9'd141, 9'd143, 9'd147, 9'd149,
    9'd150, 9'd151, 9'd152, 9'd155, 9'd157, 9'd158, 9'd165, 9'd166, 9'd168,
    9'd174, 9'd175, 9'd180, 9'd182, 9'd183, 9'd188, 9'd191, 9'd197, 9'd231,
    9'd239,
    9'd9, 9'd142, 9'd144, 9'd145, 9'd148, 9'd159, 9'd171, 9'd206, 9'd215, 9'd225,
    9'd236, 9'd237,
    9'd199, 9'd207, 9'd234, 9'd235,
    9'd192, 9'd193, 9'd200, 9'd201, 9'd202, 9'd205, 9'd210, 9'd213, 9'd218,
    9'd219, 9'd238, 9'd240, 9'd242, 9'd243, 9'd255,
    9'd203, 9'd204, 9'd211, 9'd212, 9'd214, 9'd221, 9'd222, 9'd223, 9'd241,
    9'd244, 9'd245, 9'd246, 9'd247, 9'd248, 9'd250, 9'd251, 9'd252, 9'd253,
    9'd254,
    9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd11, 9'd12, 9'd14, 9'd15, 9'd16,
    9'd17, 9'd18, 9'd19, 9'd20, 9'd21, 9'd23, 9'd24, 9'd25, 9'd26, 9'd27, 9'd28,
    9'd29, 9'd30, 9'd31, 9'd127, 9'd220, 9'd249,
    9'd10, 9'd13, 9'd22
  };

  // Symbol at a canonical index; the EOS index and any past it read as EOS
  function automatic logic [8:0] symbol_at(input logic [8:0] k);
    logic [8:0] s;
    s = EOS_SYMBOL;
    if (k < 9'd256) begin
      s = CODE_SYMBOL[k[7:0]];
    end
    return s;
  endfunction

  // Per-bit decode outcome from the bit decoder to the control
  typedef struct packed {
    logic       hit;   // a full code ends on this bit
    logic       bad;   // no code matches in the longest code length
    logic [8:0] sym;   // decoded symbol on a hit
    logic [4:0] fill;  // pending code bits
    logic       ones;  // all pending code bits are ones
  } dec_res_t;

endpackage

// ===== rtl/core/hpack_bit_dec.sv =====
// Bit-serial canonical Huffman decoder: one code bit per step.
// Depends on hpack_pkg for the code tables and result type.
module hpack_bit_dec (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 clear,
  input  logic                 code_bit,
  output hpack_pkg::dec_res_t  res
);

  logic [4:0]  fill;
  logic [29:0] code;
  logic [30:0] first;
  logic [8:0]  index;
  logic        ones;

  logic [4:0]  fill_next;
  logic [29:0] code_next;
  logic [5:0]  cnt;
  logic [30:0] diff;
  logic        match;

  // Extend the code by one bit and test it against this length's range
  always_comb begin
    fill_next = fill + 5'd1;
    code_next = {code[28:0], code_bit};
    cnt = hpack_pkg::CODE_COUNT[fill_next];
    diff = {1'b0, code_next} - first;
    match = (cnt != 6'd0) && ({1'b0, code_next} >= first) &&
            (diff[30:6] == '0) && (diff[5:0] < cnt);
    res.hit = match;
    res.bad = !match && (fill_next == 5'(hpack_pkg::MAX_CODE_BITS));
    res.sym = hpack_pkg::symbol_at(index + diff[8:0]);
    res.fill = fill;
    res.ones = ones;
  end

  // Advance the canonical walk, restart after a code ends
  always_ff @(posedge clk) begin
    if (rst || clear || (step && (res.hit || res.bad))) begin
      fill <= '0;
      code <= '0;
      first <= '0;
      index <= '0;
      ones <= 1'b1;
    end else if (step) begin
      fill <= fill_next;
      code <= code_next;
      first <= (first + {25'd0, cnt}) << 1;
      index <= index + {3'd0, cnt};
      ones <= ones & code_bit;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill < 5'(hpack_pkg::MAX_CODE_BITS))
    else $error("pending code longer than the longest code");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && (res.hit || res.bad) |=> fill == 5'd0 && ones)
    else $error("decoder did not restart after a code ended");
  a_ones: assert property (@(posedge clk) disable iff (rst)
    step && !res.hit && !res.bad && !code_bit && !clear |=> !ones)
    else $error("zero bit not recorded in padding flag");

endmodule

// ===== rtl/core/hpack_huffman_decoder_core.sv =====
// HPACK (RFC 7541) Huffman string decoder, top level.
// Each accepted byte is walked one code bit per cycle while the result side is not
// stalled; a symbol beat is valid the cycle after its last code bit is taken, and the
// final status of a string follows from the fin register once the output can take it.
// A new byte is accepted only once every bit of the last byte has been walked and, for a
// final byte, its status issued; a result beat that is not taken stalls the walk. Reset
// (rst, synchronous, active high) clears string state and sets the length limit to 4096.
module hpack_huffman_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] code_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] symbol, [23:8] decoded_length
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast,   // last
  input  logic        cfg_wen,
  input  logic [hpack_pkg::LENGTH_WIDTH-1:0] cfg_wdata  // length limit
);

  localparam int LW = hpack_pkg::LENGTH_WIDTH;

  logic [LW-1:0] len_limit;
  logic [LW-1:0] count;
  logic [2:0]    err;
  logic [7:0]    shreg;
  logic [3:0]    bits_left;
  logic          last_q;
  logic          fin;

  logic          go;
  logic          bit_go;
  logic          dec_step;
  logic          fin_go;
  hpack_pkg::dec_res_t dres;

  assign s_tready = (bits_left == 4'd0) && !fin;
  assign go = !m_tvalid || m_tready;
  assign bit_go = (bits_left != 4'd0) && go;
  assign dec_step = bit_go && (err == hpack_pkg::ST_SYMBOL);
  assign fin_go = fin && go;

  hpack_bit_dec u_dec (
    .clk      (clk),
    .rst      (rst),
    .step     (dec_step),
    .clear    (fin_go),
    .code_bit (shreg[7]),
    .res      (dres)
  );

  // Hold the length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      len_limit <= LW'(4096);
    end else if (cfg_wen) begin
      len_limit <= cfg_wdata;
    end
  end

  // Shift bits in, classify decoded codes, emit beats
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err <= hpack_pkg::ST_SYMBOL;
      bits_left <= '0;
      last_q <= 1'b0;
      fin <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_tvalid && s_tready) begin
        shreg <= s_tdata;
        bits_left <= 4'd8;
        last_q <= s_tlast;
      end
      if (bit_go) begin
        shreg <= {shreg[6:0], 1'b0};
        bits_left <= bits_left - 4'd1;
        if (bits_left == 4'd1 && last_q) begin
          fin <= 1'b1;
        end
      end
      if (dec_step) begin
        if (dres.bad || (dres.hit && dres.sym == hpack_pkg::EOS_SYMBOL)) begin
          err <= hpack_pkg::ST_INVALID;
        end else if (dres.hit && dres.sym == 9'd0) begin
          err <= hpack_pkg::ST_NUL;
        end else if (dres.hit && count >= len_limit) begin
          err <= hpack_pkg::ST_TOO_LONG;
        end else if (dres.hit) begin
          count <= count + LW'(1);
          m_tvalid <= 1'b1;
          m_tdata <= {16'(count + LW'(1)), dres.sym[7:0]};
          m_tuser <= hpack_pkg::ST_SYMBOL;
          m_tlast <= 1'b0;
        end
      end
      // Close the string with its status and drop per-string state
      if (fin_go) begin
        fin <= 1'b0;
        m_tvalid <= 1'b1;
        m_tdata <= {16'(count), 8'd0};
        m_tlast <= 1'b1;
        if (err != hpack_pkg::ST_SYMBOL) begin
          m_tuser <= err;
        end else if (dres.fill <= 5'(hpack_pkg::PAD_LIMIT) && dres.ones) begin
          m_tuser <= hpack_pkg::ST_DONE;
        end else begin
          m_tuser <= hpack_pkg::ST_PADDING;
        end
        count <= '0;
        err <= hpack_pkg::ST_SYMBOL;
      end
    end
  end

  a_no_nul: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == hpack_pkg::ST_SYMBOL |-> m_tdata[7:0] != 8'd0 && !m_tlast)
    else $error("symbol beat carries NUL or last");
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    err != hpack_pkg::ST_SYMBOL && !fin_go |=> err == $past(err))
    else $error("error code changed before the string closed");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |-> count == '0)
    else $error("count not cleared after final status");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    fin |-> bits_left == 4'd0 && !s_tready)
    else $error("final status pending while bits remain");

endmodule

// ===== tb/sv/hpack_huffman_decoder_core_tb.sv =====
// Self-checking testbench for the HPACK Huffman string decoder core.
// Depends on hpack_pkg and hpack_huffman_decoder_core; a scoreboard class decodes in step.
module hpack_huffman_decoder_core_tb;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [2:0]  status;
    logic [15:0] length;
    logic        last;
  } hp_result_t;

  int unsigned fail_count = 0;

  // Print one mismatch line and count it
  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Tracks decoder string state and holds the decoded results still due
  class huff_scoreboard;
    logic [39:0] pend_bits;
    int unsigned pend_fill;
    logic [15:0] sym_count;
    logic [2:0]  err;
    logic [15:0] max_len;
    hp_result_t  due_q[$];
    logic [8:0]  canon_sym [257];
    int unsigned len_count [31];

    function void init();
      int unsigned k;
      pend_bits = '0; pend_fill = 0; sym_count = '0; err = hpack_pkg::ST_SYMBOL;
      max_len = 16'd4096;
      for (k = 0; k < 257; k++) begin
        canon_sym[k] = hpack_pkg::symbol_at(9'(k));
      end
      for (k = 0; k < 31; k++) begin
        len_count[k] = hpack_pkg::CODE_COUNT[k];
      end
    endfunction

    // Returns 1 on a code, 0 when short of bits, -1 on no match
    function int match_front(output logic [8:0] sym, output int unsigned clen);
      int unsigned first, idx, n, code;
      first = 0; idx = 0; sym = '0; clen = 0;
      for (n = 1; n <= 30; n++) begin
        if (n > pend_fill) return 0;
        if (len_count[n] != 0) begin
          code = 32'((pend_bits >> (pend_fill - n)) & ((40'd1 << n) - 40'd1));
          if (code >= first && code - first < len_count[n]) begin
            if (idx + code - first >= 257) return -1;
            sym = canon_sym[idx + code - first];
            clen = n;
            return 1;
          end
        end
        idx += len_count[n];
        first = (first + len_count[n]) << 1;
      end
      return -1;
    endfunction

    // Note one accepted byte and queue what it decodes to
    function void note_byte(input logic [7:0] b, input logic fin);
      logic [8:0] sym;
      int unsigned clen, n;
      int r;
      logic [39:0] ones;
      logic [2:0] st;
      n = 0;
      if (err == hpack_pkg::ST_SYMBOL) begin
        pend_bits = {pend_bits[31:0], b};
        pend_fill += 8;
        forever begin
          r = match_front(sym, clen);
          if (r == 0) break;
          if (r < 0 || sym == hpack_pkg::EOS_SYMBOL) begin
            err = hpack_pkg::ST_INVALID; break;
          end
          if (sym == 0) begin err = hpack_pkg::ST_NUL; break; end
          if (sym_count >= max_len) begin err = hpack_pkg::ST_TOO_LONG; break; end
          sym_count++;
          pend_fill -= clen;
          pend_bits &= (40'd1 << pend_fill) - 1;
          if (n < 2) begin
            due_q.push_back('{sym[7:0], hpack_pkg::ST_SYMBOL, sym_count, 1'b0});
            n++;
          end
        end
      end
      if (fin) begin
        st = err;
        if (st == hpack_pkg::ST_SYMBOL) begin
          ones = (40'd1 << pend_fill) - 1;
          st = (pend_fill > hpack_pkg::PAD_LIMIT || (pend_bits & ones) != ones) ?
               hpack_pkg::ST_PADDING : hpack_pkg::ST_DONE;
        end
        due_q.push_back('{8'd0, st, sym_count, 1'b1});
        pend_bits = '0; pend_fill = 0; sym_count = '0; err = hpack_pkg::ST_SYMBOL;
      end
    endfunction

    task check(input hp_result_t got);
      hp_result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected beat %p", got));
        return;
      end
      want = due_q.pop_front();
      if (got.symbol != want.symbol)
        report($sformatf("symbol %0d want %0d", got.symbol, want.symbol));
      if (got.status != want.status)
        report($sformatf("status %0d want %0d", got.status, want.status));
      if (got.length != want.length)
        report($sformatf("length %0d want %0d", got.length, want.length));
      if (got.last != want.last)
        report($sformatf("last %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] code_byte
  logic        s_tlast = 1'b0;  // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] symbol, [23:8] decoded_length
  logic [2:0]  m_tuser;         // [2:0] status
  logic        m_tlast;
  logic        cfg_wen = 1'b0;
  logic [hpack_pkg::LENGTH_WIDTH-1:0] cfg_wdata = '0;

  hpack_huffman_decoder_core DUT (.*);

  always #1 clk = ~clk;

  huff_scoreboard sb = new();
  int unsigned send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  bit stim_done = 0;
  int unsigned quiet = 0;
  int unsigned sent = 0;
  localparam int unsigned QUIET_LIMIT = 20000;

  // Check every result beat; stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check('{m_tdata[7:0], m_tuser, m_tdata[23:8], m_tlast});
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles with no beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one byte, hold until accepted, idle at random
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1; s_tdata <= b; s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, fin);
    sent++;
  endtask

  // Drop the input and wait for every due result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    drain();
    cfg_wen <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.max_len = v;
  endtask

  // Encode symbols and send them as one string
  task automatic send_string(input logic [7:0] syms[$], input bit bad_pad,
                             input bit tail_junk);
    logic [63:0] acc;
    int unsigned fill, k, n, c, first, idx;
    acc = '0; fill = 0;
    foreach (syms[i]) begin
      // find canonical code of symbol
      first = 0; idx = 0;
      for (n = 1; n <= 30; n++) begin
        for (c = 0; c < sb.len_count[n]; c++) begin
          if (sb.canon_sym[idx + c] == {1'b0, syms[i]}) begin
            acc = (acc << n) | (first + c); fill += n;
            while (fill >= 8) begin
              send_byte(8'(acc >> (fill - 8)), 1'b0);
              fill -= 8;
            end
          end
        end
        idx += sb.len_count[n];
        first = (first + sb.len_count[n]) << 1;
      end
    end
    if (tail_junk) begin
      acc = (acc << 8) | $urandom_range(255); fill += 8;
      send_byte(8'(acc >> (fill - 8)), 1'b0); fill -= 8;
    end
    k = (1 << (8 - fill)) - 1;
    if (bad_pad) k = k ^ $urandom_range(255);
    send_byte(8'((acc << (8 - fill)) | k), 1'b1);
  endtask

  task automatic random_string(input int unsigned nsym);
    logic [7:0] syms[$];
    int unsigned r;
    repeat (nsym) begin
      r = $urandom_range(99);
      syms.push_back(r < 70 ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255)));
    end
    if ($urandom_range(99) < 3) syms.push_back(8'd0);
    send_string(syms, $urandom_range(99) < 8, $urandom_range(99) < 5);
  endtask

  initial begin
    logic [7:0] s[$];
    sb.init();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extreme bytes, EOS, NUL, bad padding, too long
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h1f, 1'b1);
    s = '{8'd0}; send_string(s, 0, 0);
    s = '{8'h30, 8'h61, 8'hff, 8'h0a}; send_string(s, 0, 0);
    s = '{8'h74}; send_string(s, 1, 0);
    s = '{8'h30, 8'h31}; send_string(s, 0, 1);
    write_max(16'd0);
    s = '{8'h61}; send_string(s, 0, 0);
    send_byte(8'hff, 1'b1);
    write_max(16'd3);
    s = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h65}; send_string(s, 0, 0);
    write_max(16'hffff);
    // Random phases, idling swapped between sides
    send_idle = 20; recv_idle = 59;
    while (sent < 160) begin random_string($urandom_range(0, 8)); end
    // Hold the receiver off so input backs up
    hold_recv = 1;
    fork
      begin repeat (400) @(posedge clk); hold_recv = 0; end
      begin random_string(12); random_string(6); drain(); end
    join
    drain();
    write_max(16'd4);
    send_idle = 59; recv_idle = 20;
    while (sent < 330) begin random_string($urandom_range(0, 7)); end
    write_max(16'd4096);
    send_idle = 0; recv_idle = 0;
    while (sent < 500) begin random_string($urandom_range(0, 9)); end
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && sb.due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
